// File: rtl/audio_hit_segmenter_macros.svh
// Assertion macros shared by the audio hit segmenter RTL.
// Every module that uses them has ports named clk and rst.
`ifndef AUDIO_HIT_SEGMENTER_MACROS_SVH
`define AUDIO_HIT_SEGMENTER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AHS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define AHS_ASSERT(lbl, prop, msg)
`define AHS_NEVER(lbl, expr, msg)
`endif
`endif

// File: rtl/ahs_pkg.sv
// Package for the audio hit segmenter: widths, constants, types and
// constant dividers. No dependencies.
package ahs_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int ADDR_W       = 12;
  localparam int CNT_W        = ADDR_W + 1;
  localparam int MAX_SAMPLES  = 1 << ADDR_W;
  localparam int SEG_CNT_W    = 7;
  localparam logic [SEG_CNT_W-1:0] MAX_SEGMENTS = 7'd64;
  localparam int ENV_FRAC     = 15;
  localparam int ENV_W        = 31;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = 2;

  localparam logic [1:0] FADE_IN_LEN = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_PERMILLE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH    = 8'd3;

  // reciprocal constants, floor(2^k / d)
  localparam logic [17:0] DIV10_M   = 18'd209715;  // k = 21
  localparam logic [11:0] DIV3_M    = 12'd2730;    // k = 13
  localparam logic [11:0] DIV1000_M = 12'd2097;    // k = 21

  typedef enum logic [3:0] {
    S_LOAD, S_SCAN_RD, S_SCAN_EV, S_BACK_RD, S_BACK_EV, S_ENV_RD0, S_ENV_INIT,
    S_ENV_RD, S_ENV_EV, S_ENV_D1, S_ENV_D2, S_EMIT, S_FINISH
  } front_state_t;

  typedef enum logic [1:0] {B_IDLE, B_DIV3, B_MUL, B_DIV} back_state_t;

  // segment word between scanner and fade-out unit
  typedef struct packed {
    logic [ADDR_W-1:0] seg_start;
    logic [CNT_W-1:0]  seg_end;
    logic              none;
    logic              last;
  } seg_word_t;

  typedef struct packed {
    logic [17:0] q;
    logic [3:0]  r;
  } div10_t;

  function automatic logic [SAMPLE_W-1:0] mag(input logic [SAMPLE_W-1:0] s);
    mag = s[SAMPLE_W-1] ? SAMPLE_W'(~s + 1'b1) : s;
  endfunction

  // x < 2^21: estimate is low by at most one, then one correction
  function automatic div10_t div10(input logic [20:0] x);
    logic [38:0] p;
    logic [17:0] q0;
    logic [4:0]  r0;
    p  = 39'(x) * 39'(DIV10_M);
    q0 = p[38:21];
    r0 = 5'(x - 21'(21'(q0) * 21'd10));
    if (r0 >= 5'd10) begin
      div10.q = q0 + 18'd1;
      div10.r = 4'(r0 - 5'd10);
    end else begin
      div10.q = q0;
      div10.r = r0[3:0];
    end
  endfunction

  function automatic logic [10:0] div3(input logic [CNT_W-1:0] x);
    logic [24:0] p;
    logic [11:0] q0;
    logic [2:0]  r0;
    p  = 25'(x) * 25'(DIV3_M);
    q0 = p[24:13];
    r0 = 3'(x - 13'(13'(q0) * 13'd3));
    div3 = (r0 >= 3'd3) ? 11'(q0 + 12'd1) : 11'(q0);
  endfunction

  function automatic logic [10:0] div1000(input logic [20:0] x);
    logic [32:0] p;
    logic [11:0] q0;
    logic [10:0] r0;
    p  = 33'(x) * 33'(DIV1000_M);
    q0 = p[32:21];
    r0 = 11'(x - 21'(21'(q0) * 21'd1000));
    div1000 = (r0 >= 11'd1000) ? 11'(q0 + 12'd1) : 11'(q0);
  endfunction

endpackage

// File: rtl/ahs_front.sv
// Front end: sample store, loading, hit scan, backtrack and envelope tracking.
// Depends on ahs_pkg and audio_hit_segmenter_macros.svh.
`include "audio_hit_segmenter_macros.svh"
module ahs_front import ahs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [SAMPLE_W-1:0] sample_value,
  input  logic                is_last_sample,
  input  logic [15:0]         hit_threshold,
  input  logic [15:0]         noise_floor_level,
  input  logic [12:0]         min_length,
  input  logic                q_full,
  output logic                q_push,
  output seg_word_t           q_word
);

  front_state_t state, state_next;

  logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
  logic [SAMPLE_W-1:0] rdata;
  logic [ADDR_W-1:0]   raddr;

  logic [CNT_W-1:0]     loaded_count;
  logic [CNT_W-1:0]     n_cnt;
  logic [CNT_W-1:0]     scan_index;
  logic [SEG_CNT_W-1:0] seg_count;
  logic [ADDR_W-1:0]    pos;
  logic [ADDR_W-1:0]    beg;
  logic                 hit_pos;
  logic [CNT_W-1:0]     fin;
  logic [ENV_W-1:0]     avg;
  logic [33:0]          v;
  logic [13:0]          q_hi;
  logic [3:0]           r_hi;
  logic                 pend_valid;
  logic [ADDR_W-1:0]    pend_start;
  logic [CNT_W-1:0]     pend_end;

  logic             in_acc;
  logic             room;
  logic [SAMPLE_W-1:0] rmag;
  logic             same_sign;
  logic             env_go;
  logic [ENV_W-1:0] floor_scaled;
  logic [13:0]      min_end;
  div10_t           d_hi;
  div10_t           d_lo;

  assign full         = (state != S_LOAD);
  assign in_acc       = push && !full;
  assign room         = !loaded_count[CNT_W-1];
  assign rmag         = mag(rdata);
  assign same_sign    = hit_pos ? (!rdata[SAMPLE_W-1] && (rdata != '0)) : rdata[SAMPLE_W-1];
  assign floor_scaled = {noise_floor_level, {ENV_FRAC{1'b0}}};
  assign min_end      = 14'(beg) + 14'(min_length);
  assign env_go       = ((avg > floor_scaled) || (14'(fin) < min_end)) && (fin < n_cnt);
  assign d_hi         = div10(21'(v[33:17]));
  assign d_lo         = div10({r_hi, v[16:0]});

  // sample store: one write port, registered read
  always_ff @(posedge clk) begin
    if (in_acc && room) begin
      mem[loaded_count[ADDR_W-1:0]] <= sample_value;
    end
    rdata <= mem[raddr];
  end

  // sequencer next state, read address and queue push
  always_comb begin
    state_next = state;
    raddr      = '0;
    q_push     = 1'b0;
    q_word     = '0;
    case (state)
      S_LOAD: begin
        if (in_acc && is_last_sample) state_next = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (scan_index >= n_cnt || seg_count == MAX_SEGMENTS) begin
          state_next = S_FINISH;
        end else begin
          raddr      = scan_index[ADDR_W-1:0];
          state_next = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        state_next = (rmag > hit_threshold) ? S_BACK_RD : S_SCAN_RD;
      end
      S_BACK_RD: begin
        if (beg == '0) begin
          state_next = S_ENV_RD0;
        end else begin
          raddr      = beg - 1'b1;
          state_next = S_BACK_EV;
        end
      end
      S_BACK_EV: begin
        state_next = same_sign ? S_BACK_RD : S_ENV_RD0;
      end
      S_ENV_RD0: begin
        raddr      = beg;
        state_next = S_ENV_INIT;
      end
      S_ENV_INIT: state_next = S_ENV_RD;
      S_ENV_RD: begin
        if (env_go) begin
          raddr      = fin[ADDR_W-1:0];
          state_next = S_ENV_EV;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_ENV_EV: state_next = S_ENV_D1;
      S_ENV_D1: state_next = S_ENV_D2;
      S_ENV_D2: state_next = S_ENV_RD;
      S_EMIT: begin
        // the held segment is not the last: a newer one replaces it
        if (!pend_valid || !q_full) begin
          q_push     = pend_valid;
          q_word     = '{seg_start: pend_start, seg_end: pend_end, none: 1'b0, last: 1'b0};
          state_next = S_SCAN_RD;
        end
      end
      S_FINISH: begin
        if (!q_full) begin
          q_push = 1'b1;
          if (pend_valid) begin
            q_word = '{seg_start: pend_start, seg_end: pend_end, none: 1'b0, last: 1'b1};
          end else begin
            q_word = '{seg_start: '0, seg_end: '0, none: 1'b1, last: 1'b1};
          end
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      n_cnt        <= '0;
      scan_index   <= '0;
      seg_count    <= '0;
      pend_valid   <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (room) loaded_count <= loaded_count + 1'b1;
            if (is_last_sample) begin
              n_cnt      <= loaded_count + CNT_W'(room);
              scan_index <= '0;
              seg_count  <= '0;
              pend_valid <= 1'b0;
            end
          end
        end
        S_SCAN_EV: begin
          if (rmag > hit_threshold) begin
            pos     <= scan_index[ADDR_W-1:0];
            beg     <= scan_index[ADDR_W-1:0];
            hit_pos <= !rdata[SAMPLE_W-1];
          end else begin
            scan_index <= scan_index + 1'b1;
          end
        end
        S_BACK_EV: begin
          if (same_sign) beg <= beg - 1'b1;
        end
        S_ENV_INIT: begin
          avg <= {rmag, {ENV_FRAC{1'b0}}};
          fin <= CNT_W'(pos);
        end
        S_ENV_EV: begin
          v <= 34'({avg, 3'b000}) + 34'(avg) + 34'({rmag, {ENV_FRAC{1'b0}}});
        end
        S_ENV_D1: begin
          q_hi <= d_hi.q[13:0];
          r_hi <= d_hi.r;
        end
        S_ENV_D2: begin
          avg <= ENV_W'({q_hi, 17'b0} + 31'(d_lo.q));
          fin <= fin + 1'b1;
        end
        S_EMIT: begin
          if (!pend_valid || !q_full) begin
            pend_start <= beg;
            pend_end   <= fin;
            pend_valid <= 1'b1;
            seg_count  <= seg_count + 1'b1;
            scan_index <= fin + CNT_W'(2);
          end
        end
        S_FINISH: begin
          if (!q_full) loaded_count <= '0;
        end
        default: ;
      endcase
    end
  end

  `AHS_ASSERT(a_seg_cap, seg_count <= MAX_SEGMENTS, "segment count past limit")
  `AHS_NEVER(a_push_full, q_push && q_full, "segment queue overrun")
  `AHS_ASSERT(a_load_cap, loaded_count <= CNT_W'(MAX_SAMPLES), "load count past store depth")

endmodule

// File: rtl/ahs_seg_queue.sv
// Short segment queue between scanner and fade-out unit.
// Depends on ahs_pkg and audio_hit_segmenter_macros.svh.
`include "audio_hit_segmenter_macros.svh"
module ahs_seg_queue import ahs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_push,
  input  seg_word_t q_wdata,
  output logic      q_full,
  input  logic      q_pop,
  output seg_word_t q_rdata,
  output logic      q_empty
);

  seg_word_t           slots [QDEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QPTR_W:0]     count;
  logic                do_push;
  logic                do_pop;

  assign q_full  = (count == (QPTR_W+1)'(QDEPTH));
  assign q_empty = (count == '0);
  assign q_rdata = slots[rptr];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  // word storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= q_wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `AHS_ASSERT(a_q_count, count <= (QPTR_W+1)'(QDEPTH), "queue count past depth")

endmodule

// File: rtl/ahs_back.sv
// Back end: fade-out length per segment and the result register.
// Depends on ahs_pkg and audio_hit_segmenter_macros.svh.
`include "audio_hit_segmenter_macros.svh"
module ahs_back import ahs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  seg_word_t         q_rdata,
  input  logic              q_empty,
  output logic              q_pop,
  input  logic [9:0]        fadeout_permille,
  output logic              empty,
  input  logic              pop,
  output logic [ADDR_W-1:0] segment_start,
  output logic [CNT_W-1:0]  segment_end,
  output logic [1:0]        fade_in_length,
  output logic [10:0]       fade_out_length,
  output logic              no_segment,
  output logic              is_last_segment
);

  back_state_t state, state_next;
  seg_word_t   cur;
  logic [10:0] q3;
  logic [20:0] prod;
  logic        out_valid;
  logic        pop_ok;
  logic        load_out;

  assign empty    = !out_valid;
  assign pop_ok   = pop && out_valid;
  assign load_out = (state == B_DIV) && (!out_valid || pop_ok);

  // step sequencer
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = B_DIV3;
        end
      end
      B_DIV3: state_next = B_MUL;
      B_MUL:  state_next = B_DIV;
      B_DIV: begin
        if (!out_valid || pop_ok) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop_ok) begin
        out_valid <= 1'b0;
      end
    end
  end

  // (len / 3) * permille / 1000, one step a cycle while the result register can take the result
  always_ff @(posedge clk) begin
    if (state == B_IDLE && !q_empty) cur <= q_rdata;
    if (state == B_DIV3) q3 <= div3(cur.seg_end - CNT_W'(cur.seg_start));
    if (state == B_MUL)  prod <= 21'(q3) * 21'(fadeout_permille);
    if (load_out) begin
      segment_start   <= cur.seg_start;
      segment_end     <= cur.seg_end;
      fade_in_length  <= cur.none ? 2'd0 : FADE_IN_LEN;
      fade_out_length <= div1000(prod);
      no_segment      <= cur.none;
      is_last_segment <= cur.last;
    end
  end

  `AHS_NEVER(a_fo_range, out_valid && (fade_out_length > 11'd1365), "fade-out out of range")

endmodule

// File: rtl/audio_hit_segmenter.sv
// Load: one sample per cycle while full is low. Scan after the flagged sample: a store
// read and a compare per non-hit sample and per backtrack step, per envelope sample a
// store read and a two-step divide by ten, then an emit per segment and a finish.
// Fade-out unit: a divide by three, a multiply and a divide by a thousand per segment, overlapped with the scan.
// Reset (rst, synchronous) clears control, loads config defaults, leaves the sample store.
// Depends on ahs_pkg, ahs_front, ahs_seg_queue, ahs_back.
module audio_hit_segmenter import ahs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [SAMPLE_W-1:0]  sample_value,
  input  logic                 is_last_sample,
  output logic                 empty,
  input  logic                 pop,
  output logic [ADDR_W-1:0]    segment_start,
  output logic [CNT_W-1:0]     segment_end,
  output logic [1:0]           fade_in_length,
  output logic [10:0]          fade_out_length,
  output logic                 no_segment,
  output logic                 is_last_segment,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [15:0] hit_threshold;
  logic [15:0] noise_floor_level;
  logic [9:0]  fadeout_permille;
  logic [12:0] min_length;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  seg_word_t q_wdata;
  seg_word_t q_rdata;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_threshold     <= 16'd16384;
      noise_floor_level <= 16'd0;
      fadeout_permille  <= 10'd0;
      min_length        <= 13'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HIT_THRESHOLD: hit_threshold     <= cfg_data;
        REG_NOISE_FLOOR:   noise_floor_level <= cfg_data;
        REG_FADE_PERMILLE: fadeout_permille  <= cfg_data[9:0];
        REG_MIN_LENGTH:    min_length        <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  ahs_front u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .sample_value      (sample_value),
    .is_last_sample    (is_last_sample),
    .hit_threshold     (hit_threshold),
    .noise_floor_level (noise_floor_level),
    .min_length        (min_length),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_word            (q_wdata)
  );

  ahs_seg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty)
  );

  ahs_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_rdata          (q_rdata),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .fadeout_permille (fadeout_permille),
    .empty            (empty),
    .pop              (pop),
    .segment_start    (segment_start),
    .segment_end      (segment_end),
    .fade_in_length   (fade_in_length),
    .fade_out_length  (fade_out_length),
    .no_segment       (no_segment),
    .is_last_segment  (is_last_segment)
  );

endmodule

// File: tb/ahs_checker.sv
// Checker for the audio hit segmenter: watches the sample, config and segment
// channels, predicts each buffer's segments and compares them. Depends on ahs_pkg.
module ahs_checker import ahs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  logic [SAMPLE_W-1:0]  sample_value,
  input  logic                 is_last_sample,
  input  logic                 empty,
  input  logic                 pop,
  input  logic [ADDR_W-1:0]    segment_start,
  input  logic [CNT_W-1:0]     segment_end,
  input  logic [1:0]           fade_in_length,
  input  logic [10:0]          fade_out_length,
  input  logic                 no_segment,
  input  logic                 is_last_segment,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   errors,
  output int                   pending,
  output int                   results_seen
);

  typedef struct packed {
    logic [ADDR_W-1:0] st;
    logic [CNT_W-1:0]  en;
    logic [1:0]        fi;
    logic [10:0]       fo;
    logic              none;
    logic              last;
  } segment_t;

  segment_t expected_segs[$];

  logic signed [SAMPLE_W-1:0] buf_mem [MAX_SAMPLES];
  int unsigned fill;
  int unsigned thr, floor_lvl, permille, min_len;

  function automatic int unsigned magn(logic signed [SAMPLE_W-1:0] s);
    return (s < 0) ? int'(-int'(s)) : int'(s);
  endfunction

  // walk the stored buffer and queue up the segments it yields
  task automatic scan_buffer();
    int unsigned n, idx, cnt, beg, fin, len;
    longint unsigned avg, flr;
    logic signed [SAMPLE_W-1:0] s;
    segment_t rec;
    n = fill;
    idx = 0;
    cnt = 0;
    flr = longint'(floor_lvl) << ENV_FRAC;
    while (idx < n && cnt < int'(MAX_SEGMENTS)) begin
      s = buf_mem[idx];
      if (magn(s) <= thr) begin
        idx++;
        continue;
      end
      // back up over the same-sign run
      beg = idx;
      if (s > 0) begin
        while (beg > 0 && buf_mem[beg-1] > 0) beg--;
      end else begin
        while (beg > 0 && buf_mem[beg-1] < 0) beg--;
      end
      // envelope follow
      avg = longint'(magn(buf_mem[beg])) << ENV_FRAC;
      fin = idx;
      while ((avg > flr || longint'(fin) < longint'(beg) + min_len) && fin < n) begin
        avg = (avg * 9 + (longint'(magn(buf_mem[fin])) << ENV_FRAC)) / 10;
        fin++;
      end
      len = fin - beg;
      rec.st = beg[ADDR_W-1:0];
      rec.en = fin[CNT_W-1:0];
      rec.fi = FADE_IN_LEN;
      rec.fo = 11'((len / 3) * permille / 1000);
      rec.none = 1'b0;
      rec.last = 1'b0;
      expected_segs.push_back(rec);
      cnt++;
      idx = fin + 2;
    end
    fill = 0;
    if (cnt == 0) begin
      rec = '0;
      rec.none = 1'b1;
      rec.last = 1'b1;
      expected_segs.push_back(rec);
    end else begin
      expected_segs[$].last = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    segment_t exp_w;
    if (rst) begin
      thr <= 16384;
      floor_lvl <= 0;
      permille <= 0;
      min_len <= 100;
      fill = 0;
      expected_segs.delete();
      errors = 0;
      results_seen <= 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HIT_THRESHOLD: thr <= cfg_data;
          REG_NOISE_FLOOR:   floor_lvl <= cfg_data;
          REG_FADE_PERMILLE: permille <= cfg_data[9:0];
          REG_MIN_LENGTH:    min_len <= cfg_data[12:0];
          default: ;
        endcase
      end
      // sample word
      if (push && !full) begin
        if (fill < MAX_SAMPLES) begin
          buf_mem[fill] = sample_value;
          fill++;
        end
        if (is_last_sample) scan_buffer();
      end
      // segment word
      if (pop && !empty) begin
        results_seen <= results_seen + 1;
        if (expected_segs.size() == 0) begin
          $error("unexpected segment word start=%0d end=%0d", segment_start, segment_end);
          errors = errors + 1;
        end else begin
          exp_w = expected_segs.pop_front();
          if (segment_start !== exp_w.st) begin
            $error("segment_start exp %0d got %0d", exp_w.st, segment_start);
            errors = errors + 1;
          end
          if (segment_end !== exp_w.en) begin
            $error("segment_end exp %0d got %0d", exp_w.en, segment_end);
            errors = errors + 1;
          end
          if (fade_in_length !== exp_w.fi) begin
            $error("fade_in_length exp %0d got %0d", exp_w.fi, fade_in_length);
            errors = errors + 1;
          end
          if (fade_out_length !== exp_w.fo) begin
            $error("fade_out_length exp %0d got %0d", exp_w.fo, fade_out_length);
            errors = errors + 1;
          end
          if (no_segment !== exp_w.none) begin
            $error("no_segment exp %0d got %0d", exp_w.none, no_segment);
            errors = errors + 1;
          end
          if (is_last_segment !== exp_w.last) begin
            $error("is_last_segment exp %0d got %0d", exp_w.last, is_last_segment);
            errors = errors + 1;
          end
        end
      end
    end
    pending = expected_segs.size();
  end

endmodule

// File: tb/audio_hit_segmenter_tb.sv
// Top of the audio hit segmenter testbench: clock, reset, sample and config
// stimulus, segment draining and verdict. Depends on ahs_pkg and ahs_checker.
module audio_hit_segmenter_tb;
  import ahs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd4;
  localparam int STALL_LIMIT = 200000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [SAMPLE_W-1:0]  sample_value = '0;
  logic                 is_last_sample = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [ADDR_W-1:0]    segment_start;
  logic [CNT_W-1:0]     segment_end;
  logic [1:0]           fade_in_length;
  logic [10:0]          fade_out_length;
  logic                 no_segment;
  logic                 is_last_segment;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  int  errors, pending, results_seen;
  bit  idle_en = 1'b1;
  bit  hold_req = 1'b0;
  int  buffers_sent = 0;
  int  stall_cnt = 0;

  always #5 clk = ~clk;

  audio_hit_segmenter u_dut (.*);

  ahs_checker u_chk (.*);

  // sample word with random gaps
  task automatic send_sample(logic [15:0] v, logic l);
    while (idle_en && $urandom_range(99) < 17) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    sample_value <= v;
    is_last_sample <= l;
    do @(posedge clk); while (full);
    if (l) buffers_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // hold off until every segment is back, then let the pipeline settle
  task automatic drain_all();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_config(int thr, int flr, int perm, int mlen);
    write_reg(REG_HIT_THRESHOLD, 16'(thr));
    write_reg(REG_NOISE_FLOOR, 16'(flr));
    write_reg(REG_FADE_PERMILLE, 16'(perm));
    write_reg(REG_MIN_LENGTH, 16'(mlen));
  endtask

  function automatic logic [15:0] rand_sample(int sign_bias);
    int k;
    logic [15:0] v;
    k = $urandom_range(9);
    if (k < 4) begin
      v = 16'($urandom_range(1500));
    end else if (k < 7) begin
      v = 16'($urandom);
    end else begin
      v = 16'($urandom_range(32767, 12000));
    end
    if (k < 4 || k >= 7) begin
      if (sign_bias != 0) v = -v;
    end
    return v;
  endfunction

  // random buffers, mostly short with runs of one sign
  task automatic random_buffers(int nitems);
    int cnt, len, sgn;
    cnt = 0;
    while (cnt < nitems) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(30, 1);
      sgn = $urandom_range(1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(5) == 0) sgn = $urandom_range(1);
        send_sample(rand_sample(sgn), i == len - 1);
      end
      cnt += len;
    end
  endtask

  // segment drain with random gaps and one long hold-off
  initial begin
    int hold_cnt;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 0;
        pop <= 1'b0;
        while (hold_cnt < 400) begin
          @(posedge clk);
          hold_cnt++;
        end
      end
      pop <= !(idle_en && $urandom_range(99) < 17);
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("[audio_hit_segmenter] ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset config: extremes, threshold edge, backtrack to index 0
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFF00, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h4000, 1'b0);
    send_sample(16'h4001, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hC000, 1'b0);
    send_sample(16'hBFFF, 1'b1);
    drain_all();
    set_config(100, 16'hFFFF, 16'hFFFF, 0);
    write_reg(REG_UNUSED, 16'h5A5A);
    drain_all();
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0050, 1'b1);
    drain_all();

    // several settings, extremes among them
    set_config(0, 0, 1000, 0);
    random_buffers(20);
    drain_all();
    set_config(32768, 32768, 0, 4096);
    random_buffers(10);
    drain_all();
    set_config(16384, 300, 500, 8);
    hold_req = 1'b1;
    random_buffers(40);
    drain_all();
    idle_en = 1'b0;
    set_config($urandom_range(32768), $urandom_range(4000), $urandom_range(1000),
               $urandom_range(200));
    random_buffers(40);
    drain_all();
    idle_en = 1'b1;
    set_config($urandom_range(30000, 5000), $urandom_range(2000), $urandom_range(1000),
               $urandom_range(40));
    random_buffers(20);
    drain_all();

    // more hits than the segment limit allows
    set_config(100, 32768, 1000, 0);
    for (int i = 0; i < 132; i++)
      send_sample((i % 2) ? 16'h0000 : ((i % 4) ? 16'hB1E0 : 16'h4E20), i == 131);
    drain_all();
    repeat (100) @(posedge clk);

    $display("covered %0d buffers and %0d segment words over several settings,",
             buffers_sent, results_seen);
    $display("including the segment limit and output back-pressure");
    if (errors == 0 && pending == 0) begin
      $display("[audio_hit_segmenter] OK");
    end else begin
      $display("[audio_hit_segmenter] ERROR");
    end
    $finish;
  end

endmodule
